FILE: design/cxy_pkg.sv
// ----------------------------------------------------------------------------
// cxy_pkg
// Shared constants for the CoreXY line step generator: operation codes,
// scale arithmetic constants and the bit layouts of the input and result words.
// ----------------------------------------------------------------------------
package cxy_pkg;

	// Operation codes carried on the input tuser bit.
	localparam logic OP_MOVE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Pulses per millimetre after reset, Q8.8 (300 / 25.4).
	localparam logic [15:0] PPM_RESET = 16'd3024;

	// |delta| * pulses_per_mm is 1/16 mm times Q8.8, so counts come out
	// after a shift of 4 + 8 + 1 bits, rounded up.
	localparam int SCALE_SHIFT = 13;
	localparam logic [12:0] ROUND_BIAS = 13'h1fff;

	// Input tdata layout.
	localparam int IN_DATA_W = 40;
	localparam int IN_TX_LSB = 0;
	localparam int IN_TY_LSB = 16;
	localparam int IN_PEN_BIT = 32;

	// Result tdata layout.
	localparam int OUT_DATA_W = 8;
	localparam int OUT_STEP_ONE = 0;
	localparam int OUT_STEP_TWO = 1;
	localparam int OUT_DIR_ONE = 2;
	localparam int OUT_DIR_TWO = 3;
	localparam int OUT_PEN = 4;
	localparam int OUT_BUSY = 5;
	localparam int OUT_REJECTED = 6;

endpackage

FILE: design/cxy_to_count.sv
// ----------------------------------------------------------------------------
// cxy_to_count
// Converts a signed belt displacement in 1/16 mm into a motor step count:
// ceil(|d| * pulses_per_mm / 8192), saturated to the count width.
// ----------------------------------------------------------------------------
module cxy_to_count #(
	parameter int DW = 18,
	parameter int COUNT_WIDTH = 16
) (
	input  logic signed [DW-1:0]          delta,
	input  logic        [15:0]            scale,
	output logic        [COUNT_WIDTH-1:0] count
);

	localparam int PW = DW + 16;
	localparam int SW = PW + 1;
	localparam int QW = SW - cxy_pkg::SCALE_SHIFT;

	logic [DW-1:0] mag;
	logic [PW-1:0] prod;
	logic [SW-1:0] sum;
	logic [QW-1:0] quo;

	// The most negative delta still fits as an unsigned magnitude.
	assign mag  = delta[DW-1] ? (~delta + DW'(1)) : delta;
	assign prod = PW'(mag) * PW'(scale);
	assign sum  = {1'b0, prod} + SW'(cxy_pkg::ROUND_BIAS);
	assign quo  = sum[SW-1:cxy_pkg::SCALE_SHIFT];

	generate
		if (QW > COUNT_WIDTH) begin : g_sat
			assign count = (|quo[QW-1:COUNT_WIDTH]) ? {COUNT_WIDTH{1'b1}}
				: quo[COUNT_WIDTH-1:0];
		end else begin : g_ext
			assign count = COUNT_WIDTH'(quo);
		end
	endgenerate

endmodule

FILE: design/corexy_line_step_generator.sv
// ----------------------------------------------------------------------------
// corexy_line_step_generator
// Line interpolation for a two-belt CoreXY plotter: move requests set up
// belt step counts, tick requests issue step pulses spread along the line.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on s_tvalid/s_tready. s_tuser selects a move (0)
//   or a step tick (1). A move carries the target position and pen state in
//   s_tdata; a tick ignores s_tdata. Every request yields exactly one result
//   on m_tvalid/m_tready, with step pulses, directions, pen level and busy
//   in m_tdata and the final step of a move flagged on m_tlast.
//   A move that arrives while steps remain is dropped and reported rejected.
//   Users write pulses_per_mm via cfg_we/cfg_wdata while idle; not enforced.
// Timing:
//   One request is taken every cycle unless the result side stalls. A
//   request is held in the input register; the state update and the result
//   are computed in one pass between that register and the result register,
//   which drives the outputs. The per-tick path holds two
//   count-by-count multiplies and a compare in parallel.
//   When m_tready is low the result register holds and the input register
//   keeps one more request; s_tready drops only when both are full.
//   Reset clears position, counts, pen and directions, and reloads
//   pulses_per_mm with 3024.
// ----------------------------------------------------------------------------
module corexy_line_step_generator #(
	parameter int COORD_WIDTH = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata: target_x[15:0], target_y[31:16], pen_down[32], zero pad
	input  logic [cxy_pkg::IN_DATA_W-1:0]   s_tdata,
	// s_tuser: op[0]
	input  logic [0:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: step_one, step_two, dir_one, dir_two, pen_level, busy_res,
	// rejected, zero pad (bit 7)
	output logic [cxy_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [15:0]                     cfg_wdata
);

	localparam int MW = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;
	localparam int DW = MW + 2;
	localparam int PW = 2 * COUNT_WIDTH;

	// Input register.
	logic               valid_s1;
	logic               op_s1;
	logic signed [15:0] tx_s1;
	logic signed [15:0] ty_s1;
	logic               pen_s1;

	// Block state.
	logic [15:0]            scale_q;
	logic [COORD_WIDTH-1:0] pos_x_q;
	logic [COORD_WIDTH-1:0] pos_y_q;
	logic                   pen_q;
	logic [1:0]             dir_q;
	logic [COUNT_WIDTH-1:0] total_one_q;
	logic [COUNT_WIDTH-1:0] total_two_q;
	logic [COUNT_WIDTH-1:0] remain_one_q;
	logic [COUNT_WIDTH-1:0] remain_two_q;

	// Result register.
	logic                           out_valid_q;
	logic [cxy_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                           out_last_q;

	logic adv;
	logic busy;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign busy     = (remain_one_q != '0) || (remain_two_q != '0);

	// Move arithmetic.
	logic signed [DW-1:0]   txe, tye, pxe, pye, dx, dy, da, db;
	logic [DW-1:0]          adx, ady;
	logic [1:0]             mv_dir;
	logic [COUNT_WIDTH-1:0] cnt_one, cnt_two;

	assign txe = DW'(tx_s1);
	assign tye = DW'(ty_s1);
	assign pxe = {{(DW-COORD_WIDTH){pos_x_q[COORD_WIDTH-1]}}, pos_x_q};
	assign pye = {{(DW-COORD_WIDTH){pos_y_q[COORD_WIDTH-1]}}, pos_y_q};
	assign dx  = txe - pxe;
	assign dy  = tye - pye;
	assign da  = dx + dy;
	assign db  = dy - dx;
	assign adx = dx[DW-1] ? (~dx + DW'(1)) : dx;
	assign ady = dy[DW-1] ? (~dy + DW'(1)) : dy;

	// Directions: bit 0 is motor one, bit 1 is motor two.
	always_comb begin
		if (adx > ady) begin
			mv_dir = dx[DW-1] ? 2'b10 : 2'b01;
		end else begin
			mv_dir = dy[DW-1] ? 2'b00 : 2'b11;
		end
	end

	cxy_to_count #(.DW(DW), .COUNT_WIDTH(COUNT_WIDTH)) u_count_one (
		.delta(da),
		.scale(scale_q),
		.count(cnt_one)
	);

	cxy_to_count #(.DW(DW), .COUNT_WIDTH(COUNT_WIDTH)) u_count_two (
		.delta(db),
		.scale(scale_q),
		.count(cnt_two)
	);

	// Tick arithmetic: the larger total is the major motor, motor one on a tie.
	logic                   one_major;
	logic [COUNT_WIDTH-1:0] r_maj, r_min, t_maj, t_min;
	logic [PW-1:0]          cross_min, cross_maj;
	logic                   step_maj, step_min;
	logic [COUNT_WIDTH-1:0] r_maj_nxt, r_min_nxt;

	assign one_major = total_one_q >= total_two_q;
	assign r_maj     = one_major ? remain_one_q : remain_two_q;
	assign r_min     = one_major ? remain_two_q : remain_one_q;
	assign t_maj     = one_major ? total_one_q : total_two_q;
	assign t_min     = one_major ? total_two_q : total_one_q;
	assign cross_min = PW'(r_min) * PW'(t_maj);
	assign cross_maj = PW'(r_maj) * PW'(t_min);
	assign step_maj  = r_maj != '0;
	assign step_min  = (r_min != '0) && (cross_min >= cross_maj);
	assign r_maj_nxt = step_maj ? r_maj - COUNT_WIDTH'(1) : r_maj;
	assign r_min_nxt = step_min ? r_min - COUNT_WIDTH'(1) : r_min;

	// Next state and result for the item in the input register.
	logic [COORD_WIDTH-1:0] pos_x_nxt, pos_y_nxt;
	logic                   pen_nxt;
	logic [1:0]             dir_nxt;
	logic [COUNT_WIDTH-1:0] tot_one_nxt, tot_two_nxt, rem_one_nxt, rem_two_nxt;
	logic                   s_one, s_two, last_nxt, rej_nxt;
	logic [cxy_pkg::OUT_DATA_W-1:0] res_word;

	always_comb begin
		pos_x_nxt   = pos_x_q;
		pos_y_nxt   = pos_y_q;
		pen_nxt     = pen_q;
		dir_nxt     = dir_q;
		tot_one_nxt = total_one_q;
		tot_two_nxt = total_two_q;
		rem_one_nxt = remain_one_q;
		rem_two_nxt = remain_two_q;
		s_one       = 1'b0;
		s_two       = 1'b0;
		last_nxt    = 1'b0;
		rej_nxt     = 1'b0;
		if (op_s1 == cxy_pkg::OP_MOVE) begin
			if (busy) begin
				rej_nxt = 1'b1;
			end else begin
				pos_x_nxt   = txe[COORD_WIDTH-1:0];
				pos_y_nxt   = tye[COORD_WIDTH-1:0];
				pen_nxt     = pen_s1;
				dir_nxt     = mv_dir;
				tot_one_nxt = cnt_one;
				tot_two_nxt = cnt_two;
				rem_one_nxt = cnt_one;
				rem_two_nxt = cnt_two;
			end
		end else if (busy) begin
			if (one_major) begin
				rem_one_nxt = r_maj_nxt;
				rem_two_nxt = r_min_nxt;
				s_one       = step_maj;
				s_two       = step_min;
			end else begin
				rem_two_nxt = r_maj_nxt;
				rem_one_nxt = r_min_nxt;
				s_two       = step_maj;
				s_one       = step_min;
			end
			last_nxt = (rem_one_nxt == '0) && (rem_two_nxt == '0);
		end
	end

	always_comb begin
		res_word                        = '0;
		res_word[cxy_pkg::OUT_STEP_ONE] = s_one;
		res_word[cxy_pkg::OUT_STEP_TWO] = s_two;
		res_word[cxy_pkg::OUT_DIR_ONE]  = dir_nxt[0];
		res_word[cxy_pkg::OUT_DIR_TWO]  = dir_nxt[1];
		res_word[cxy_pkg::OUT_PEN]      = pen_nxt;
		res_word[cxy_pkg::OUT_BUSY]     = (rem_one_nxt != '0) || (rem_two_nxt != '0);
		res_word[cxy_pkg::OUT_REJECTED] = rej_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= s_tuser[0];
			tx_s1  <= s_tdata[cxy_pkg::IN_TX_LSB +: 16];
			ty_s1  <= s_tdata[cxy_pkg::IN_TY_LSB +: 16];
			pen_s1 <= s_tdata[cxy_pkg::IN_PEN_BIT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= cxy_pkg::PPM_RESET;
		end else if (cfg_we) begin
			scale_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			pen_q        <= 1'b0;
			dir_q        <= 2'b00;
			total_one_q  <= '0;
			total_two_q  <= '0;
			remain_one_q <= '0;
			remain_two_q <= '0;
		end else if (adv) begin
			pos_x_q      <= pos_x_nxt;
			pos_y_q      <= pos_y_nxt;
			pen_q        <= pen_nxt;
			dir_q        <= dir_nxt;
			total_one_q  <= tot_one_nxt;
			total_two_q  <= tot_two_nxt;
			remain_one_q <= rem_one_nxt;
			remain_two_q <= rem_two_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res_word;
			out_last_q <= last_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: design/cxy_checker.sv
// ----------------------------------------------------------------------------
// cxy_checker
// Port-level checks for the CoreXY line step generator: result stalls and
// consistency of step, last and rejected results with the busy history.
// ----------------------------------------------------------------------------
module cxy_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [cxy_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic                            m_tlast
);

	logic m_acc;
	logic prev_busy_q;

	assign m_acc = m_tvalid && m_tready;

	// Busy flag of the most recently delivered result; idle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_busy_q <= 1'b0;
		end else if (m_acc) begin
			prev_busy_q <= m_tdata[cxy_pkg::OUT_BUSY];
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc && m_tdata[cxy_pkg::OUT_REJECTED] |-> prev_busy_q)
		else $error("move rejected while idle");

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc && (m_tdata[cxy_pkg::OUT_STEP_ONE] || m_tdata[cxy_pkg::OUT_STEP_TWO])
		|-> prev_busy_q)
		else $error("step pulse issued while idle");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc && m_tlast |-> prev_busy_q && !m_tdata[cxy_pkg::OUT_BUSY])
		else $error("last step flag without a finishing move");

endmodule

bind corexy_line_step_generator cxy_checker u_cxy_checker (.*);

FILE: sim/corexy_line_step_generator_test.sv
// ----------------------------------------------------------------------------
// corexy_line_step_generator_test
// Streams move and tick requests into the CoreXY line step generator. A
// model of the plotter state computes the result of each accepted request,
// and each returned result is checked bit by bit against the oldest one
// still waiting. The run covers several scale settings and several idling
// patterns, including one long stall of the result side.
// ----------------------------------------------------------------------------
module corexy_line_step_generator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic               op;
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		logic               pen;
	} plot_cmd_t;

	typedef struct {
		logic s1;
		logic s2;
		logic d1;
		logic d2;
		logic pen;
		logic busy;
		logic last;
		logic rej;
	} pulse_word_t;

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [cxy_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]                     s_tuser = cxy_pkg::OP_TICK;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [cxy_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tlast;
	logic                           cfg_we = 1'b0;
	logic [15:0]                    cfg_wdata = '0;

	// Plotter state as the block should hold it.
	logic [15:0]        cur_ppm = cxy_pkg::PPM_RESET;
	logic signed [15:0] pos_x = '0;
	logic signed [15:0] pos_y = '0;
	logic               pen_state = 1'b0;
	logic [15:0]        tot_one = '0;
	logic [15:0]        tot_two = '0;
	logic [15:0]        rem_one = '0;
	logic [15:0]        rem_two = '0;
	logic [1:0]         dirs = '0;

	plot_cmd_t   command_fifo[$];
	pulse_word_t expected_pulses[$];
	plot_cmd_t   live_cmd;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;
	int gen_x = 0;
	int gen_y = 0;
	int unsigned cycle_count = 0;

	corexy_line_step_generator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Belt step count for a belt displacement in 1/16 mm, rounded up.
	function automatic logic [15:0] belt_count(longint d, logic [15:0] ppm);
		longint scale;
		longint steps;
		scale = longint'(ppm);
		steps = (mag(d) * scale + 8191) >>> cxy_pkg::SCALE_SHIFT;
		return (steps > 65535) ? 16'hffff : steps[15:0];
	endfunction

	function automatic pulse_word_t advance_plotter(plot_cmd_t c);
		pulse_word_t r;
		logic        busy;
		logic        one_major;
		logic        st_maj;
		logic        st_min;
		longint      dx;
		longint      dy;
		logic [15:0] r_maj;
		logic [15:0] r_min;
		logic [15:0] t_maj;
		logic [15:0] t_min;
		r = '{default: 1'b0};
		busy = (rem_one != 0) || (rem_two != 0);
		if (c.op == cxy_pkg::OP_MOVE) begin
			if (busy) begin
				r.rej = 1'b1;
			end else begin
				dx = longint'(c.tx) - longint'(pos_x);
				dy = longint'(c.ty) - longint'(pos_y);
				if (mag(dx) > mag(dy)) begin
					dirs = (dx >= 0) ? 2'b01 : 2'b10;
				end else begin
					dirs = (dy >= 0) ? 2'b11 : 2'b00;
				end
				tot_one = belt_count(dx + dy, cur_ppm);
				tot_two = belt_count(dy - dx, cur_ppm);
				rem_one = tot_one;
				rem_two = tot_two;
				pos_x = c.tx;
				pos_y = c.ty;
				pen_state = c.pen;
			end
		end else if (busy) begin
			// The belt with more steps leads; the other follows whenever it
			// has fallen behind its share of the line.
			one_major = tot_one >= tot_two;
			r_maj = one_major ? rem_one : rem_two;
			r_min = one_major ? rem_two : rem_one;
			t_maj = one_major ? tot_one : tot_two;
			t_min = one_major ? tot_two : tot_one;
			st_maj = r_maj != 0;
			st_min = (r_min != 0) &&
				(longint'(r_min) * longint'(t_maj) >= longint'(r_maj) * longint'(t_min));
			if (st_maj) r_maj = r_maj - 16'd1;
			if (st_min) r_min = r_min - 16'd1;
			if (one_major) begin
				rem_one = r_maj;
				rem_two = r_min;
				r.s1 = st_maj;
				r.s2 = st_min;
			end else begin
				rem_two = r_maj;
				rem_one = r_min;
				r.s2 = st_maj;
				r.s1 = st_min;
			end
			r.last = (rem_one == 0) && (rem_two == 0);
		end
		r.d1 = dirs[0];
		r.d2 = dirs[1];
		r.pen = pen_state;
		r.busy = (rem_one != 0) || (rem_two != 0);
		return r;
	endfunction

	task automatic check_bit(string name, logic want, logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			fail_count++;
		end
	endtask

	task automatic push_move(int x, int y, logic pen);
		plot_cmd_t c;
		c.op = cxy_pkg::OP_MOVE;
		c.tx = 16'(x);
		c.ty = 16'(y);
		c.pen = pen;
		command_fifo.push_back(c);
	endtask

	task automatic push_ticks(int n);
		plot_cmd_t c;
		repeat (n) begin
			c.op = cxy_pkg::OP_TICK;
			c.tx = 16'($urandom);
			c.ty = 16'($urandom);
			c.pen = 1'($urandom);
			command_fifo.push_back(c);
		end
	endtask

	// A move followed by the ticks that finish it. With a cut inside the
	// line, a stray move lands while steps remain and must be rejected.
	task automatic line_to(int x, int y, logic pen, int cut, int extra);
		int c1;
		int c2;
		int span;
		c1 = int'(belt_count(longint'(x + y - gen_x - gen_y), cur_ppm));
		c2 = int'(belt_count(longint'(y - x - gen_y + gen_x), cur_ppm));
		span = (c1 > c2) ? c1 : c2;
		push_move(x, y, pen);
		if (cut > 0 && cut < span) begin
			push_ticks(cut);
			push_move($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
				1'($urandom));
			push_ticks(span - cut + extra);
		end else begin
			push_ticks(span + extra);
		end
		gen_x = x;
		gen_y = y;
	endtask

	function automatic int clip16(int v);
		return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
	endfunction

	// Mostly complete lines with random targets, some cut by a stray move,
	// some loose ticks. A reach of zero draws targets over the whole range.
	task automatic random_burst(int quota, int reach);
		int start;
		int kind;
		int x;
		int y;
		start = command_fifo.size();
		while (command_fifo.size() - start < quota) begin
			if (reach == 0) begin
				x = $urandom_range(65535) - 32768;
				y = $urandom_range(65535) - 32768;
			end else begin
				x = clip16(gen_x + $urandom_range(2 * reach) - reach);
				y = clip16(gen_y + $urandom_range(2 * reach) - reach);
			end
			kind = $urandom_range(99);
			if (kind < 70) begin
				line_to(x, y, 1'($urandom), 0, $urandom_range(2));
			end else if (kind < 85) begin
				line_to(x, y, 1'($urandom), $urandom_range(1, 6), 2);
			end else begin
				push_ticks($urandom_range(1, 3));
			end
		end
	endtask

	task automatic settle();
		while (command_fifo.size() != 0 || s_tvalid || expected_pulses.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		gen_x = int'(pos_x);
		gen_y = int'(pos_y);
	endtask

	task automatic load_scale(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_ppm = v;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("corexy_line_step_generator_test NOT OK");
			$finish;
		end
	end

	// Request side.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_pulses.push_back(advance_plotter(live_cmd));
			if (!s_tvalid || s_tready) begin
				if (command_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					live_cmd = command_fifo.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= live_cmd.op;
					s_tdata <= {7'd0, live_cmd.pen, live_cmd.ty, live_cmd.tx};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side, with one long stall once some results have come back.
	int          results_seen = 0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	pulse_word_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_pulses.size() == 0) begin
					$error("result with no request waiting: tdata %h, tlast %0b",
						m_tdata, m_tlast);
					fail_count++;
				end else begin
					want = expected_pulses.pop_front();
					check_bit("step_one", want.s1, m_tdata[cxy_pkg::OUT_STEP_ONE]);
					check_bit("step_two", want.s2, m_tdata[cxy_pkg::OUT_STEP_TWO]);
					check_bit("dir_one", want.d1, m_tdata[cxy_pkg::OUT_DIR_ONE]);
					check_bit("dir_two", want.d2, m_tdata[cxy_pkg::OUT_DIR_TWO]);
					check_bit("pen_level", want.pen, m_tdata[cxy_pkg::OUT_PEN]);
					check_bit("busy_res", want.busy, m_tdata[cxy_pkg::OUT_BUSY]);
					check_bit("rejected", want.rej, m_tdata[cxy_pkg::OUT_REJECTED]);
					check_bit("last", want.last, m_tlast);
				end
				results_seen++;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (results_seen == HOLD_AT && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset scale. Idle tick, zero-length move, every direction branch,
		// equal belt counts, a zero count on one belt, a move while busy.
		send_idle_pct = 25;
		recv_idle_pct = 61;
		push_ticks(1);
		line_to(0, 0, 1'b1, 0, 0);
		line_to(3, 1, 1'b1, 0, 0);
		line_to(-1, 2, 1'b0, 1, 0);
		line_to(-1, 5, 1'b1, 0, 1);
		line_to(1, 3, 1'b1, 0, 0);
		line_to(0, -1, 1'b0, 0, 0);
		random_burst(400, 40);
		settle();

		// Smallest nonzero scale: coordinate extremes and full-range targets.
		send_idle_pct = 61;
		recv_idle_pct = 25;
		load_scale(16'd1);
		line_to(-32768, 32767, 1'b1, 0, 0);
		line_to(32767, -32768, 1'b0, 4, 1);
		line_to(32767, 32767, 1'b1, 0, 0);
		line_to(-32768, -32768, 1'b0, 0, 0);
		random_burst(300, 0);
		settle();

		// Zero scale leaves every count at zero.
		load_scale(16'd0);
		line_to(200, -300, 1'b1, 0, 1);
		line_to(-5, 7, 1'b0, 0, 0);
		settle();
		load_scale(16'hffff);
		random_burst(300, 3);
		settle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_scale(16'd500);
		random_burst(300, 200);
		settle();
		load_scale(16'd4097);
		random_burst(200, 30);
		settle();

		// A long purely horizontal line at the largest scale saturates both
		// counts; a few ticks and a rejected move follow, and it stays open.
		load_scale(16'hffff);
		push_move((gen_x < 0) ? 32767 : -32768, gen_y, 1'b1);
		push_ticks(40);
		push_move(0, 0, 1'b0);
		push_ticks(10);
		settle();

		if (fail_count == 0) begin
			$display("corexy_line_step_generator_test OK");
		end else begin
			$display("corexy_line_step_generator_test NOT OK");
		end
		$finish;
	end

endmodule
